FILE: rtl/wpsm_pkg.sv
// ----------------------------------------------------------------------------
// wpsm_pkg: shared types and constants for the window prefetch slot manager
// Command codes, slot states, beat payloads and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package wpsm_pkg;

   // default sizing
   localparam int DEF_SLOTS  = 6;
   localparam int DEF_AHEAD  = 2;
   localparam int DEF_BEHIND = 1;

   // ready_mask only reports the low slots
   localparam int MASK_W = 6;

   typedef enum logic [2:0] {
      OP_FOCUS     = 3'd0,
      OP_CLAIM     = 3'd1,
      OP_LOAD_DONE = 3'd2,
      OP_SWEEP     = 3'd3,
      OP_UPLOAD    = 3'd4,
      OP_LOOKUP    = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      SL_FREE    = 3'd0,
      SL_LOADING = 3'd1,
      SL_PIXELS  = 3'd2,
      SL_TEXTURE = 3'd3,
      SL_FAILED  = 3'd4
   } slot_state_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] page;
      logic [2:0]  slot;
      logic        ok;
      logic [15:0] width;
      logic [15:0] height;
   } req_type;

   typedef struct packed {
      logic              valid_res;
      logic [15:0]       page_out;
      logic [2:0]        slot_out;
      logic [15:0]       width_out;
      logic [15:0]       height_out;
      logic              failed;
      logic              freed;
      logic [MASK_W-1:0] ready_mask;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // latch the request beat, restart the candidate walk
      logic exec;        // run a single-step command
      logic cand_next;   // move to the next claim candidate
      logic claim_done;  // finish the claim with the current candidate
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] op;
      logic       cand_ok;
      logic       cand_last;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/wpsm_ctrl.sv
// ----------------------------------------------------------------------------
// wpsm_ctrl: command sequencer
// Accepts a request beat, runs it on the datapath and holds the response.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsm_ctrl import wpsm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       ctrl
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EXEC   = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_type'(status.op) == OP_CLAIM) begin
               state_in = ST_SEARCH;
            end else begin
               ctrl.exec = 1'b1;
               state_in  = ST_RESP;
            end
         end
         ST_SEARCH: begin
            // one candidate page per cycle
            if (status.cand_ok || status.cand_last) begin
               ctrl.claim_done = 1'b1;
               state_in        = ST_RESP;
            end else begin
               ctrl.cand_next = 1'b1;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/wpsm_datapath.sv
// ----------------------------------------------------------------------------
// wpsm_datapath: slot table, candidate walker and response register
// Per-slot compare lanes, lowest-index pickers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wpsm_datapath import wpsm_pkg::*; #(
   parameter int SLOTS  = DEF_SLOTS,
   parameter int AHEAD  = DEF_AHEAD,
   parameter int BEHIND = DEF_BEHIND
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  ctrl,
   output dp_status_type      status,
   input  wire req_type       req_data,
   input  wire logic          csr_we,
   input  wire logic [15:0]   csr_wdata,
   output rsp_type            rsp_data
);

   localparam int SW    = $clog2(SLOTS);
   localparam int NCAND = AHEAD + BEHIND + 1;
   localparam int KW    = $clog2(NCAND + 1);
   localparam int MW    = (SLOTS < MASK_W) ? SLOTS : MASK_W;

   logic [15:0]    pcount_ff, pcount_in;
   logic [15:0]    focus_ff, focus_in;
   logic [KW-1:0]  k_ff, k_in;
   req_type        req_ff;
   rsp_type        res_ff, res_in;
   slot_state_type status_ff [SLOTS];
   slot_state_type status_in [SLOTS];
   logic [15:0]    page_ff   [SLOTS];
   logic [15:0]    width_ff  [SLOTS];
   logic [15:0]    height_ff [SLOTS];

   logic [SLOTS-1:0] empty, pg_hit, cand_hit, evict;
   logic [SW-1:0]    free_idx, hit_idx, sel_idx;
   logic             sel_in_range;
   logic [17:0]      cand_sum;
   logic             cand_ok;
   logic             page_we, size_we;
   int               off;

   // candidate: focus, then ahead, then behind
   always_comb begin
      off      = (int'(k_ff) <= AHEAD) ? int'(k_ff) : AHEAD - int'(k_ff);
      cand_sum = {2'b00, focus_ff} + 18'(off);
   end

   // per-slot lanes
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         empty[i]    = (status_ff[i] == SL_FREE);
         pg_hit[i]   = !empty[i] && (page_ff[i] == req_ff.page);
         cand_hit[i] = !empty[i] && (page_ff[i] == cand_sum[15:0]);
         evict[i]    = ((status_ff[i] == SL_PIXELS) || (status_ff[i] == SL_TEXTURE) ||
                        (status_ff[i] == SL_FAILED)) &&
                       !(({1'b0, page_ff[i]} + 17'(BEHIND) >= {1'b0, focus_ff}) &&
                         ({1'b0, page_ff[i]} <= {1'b0, focus_ff} + 17'(AHEAD)) &&
                         (page_ff[i] < pcount_ff));
      end
   end

   // lowest-index pickers
   always_comb begin
      free_idx = '0;
      hit_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (empty[i]) free_idx = SW'(i);
         if (pg_hit[i]) hit_idx = SW'(i);
      end
   end

   assign cand_ok = !cand_sum[17] && (cand_sum[16:0] < {1'b0, pcount_ff}) && !(|cand_hit);
   assign sel_idx = SW'(req_ff.slot);
   assign sel_in_range = (int'(req_ff.slot) < SLOTS);

   assign status.op        = req_ff.cmd;
   assign status.cand_ok   = cand_ok;
   assign status.cand_last = (k_ff == KW'(NCAND - 1));

   always_comb begin
      status_in = status_ff;
      res_in    = '0;
      focus_in  = focus_ff;
      page_we   = 1'b0;
      size_we   = 1'b0;
      if (ctrl.exec) begin
         case (op_type'(req_ff.cmd))
            OP_FOCUS: begin
               focus_in = req_ff.page;
            end
            OP_LOAD_DONE: begin
               if (sel_in_range && status_ff[sel_idx] == SL_LOADING) begin
                  size_we            = req_ff.ok;
                  status_in[sel_idx] = req_ff.ok ? SL_PIXELS : SL_FAILED;
               end
            end
            OP_SWEEP: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (evict[i]) status_in[i] = SL_FREE;
               end
               res_in.freed = |evict;
            end
            OP_UPLOAD: begin
               if (sel_in_range && status_ff[sel_idx] == SL_PIXELS) begin
                  status_in[sel_idx] = req_ff.ok ? SL_TEXTURE : SL_FAILED;
               end
            end
            OP_LOOKUP: begin
               if (|pg_hit) begin
                  res_in.slot_out = 3'(hit_idx);
                  if (status_ff[hit_idx] == SL_TEXTURE) begin
                     res_in.valid_res  = 1'b1;
                     res_in.width_out  = width_ff[hit_idx];
                     res_in.height_out = height_ff[hit_idx];
                  end else if (status_ff[hit_idx] == SL_FAILED) begin
                     res_in.failed = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      // claim: a found page with no empty slot ends the search ungranted
      if (ctrl.claim_done && cand_ok && (|empty)) begin
         status_in[free_idx] = SL_LOADING;
         page_we             = 1'b1;
         res_in.valid_res    = 1'b1;
         res_in.page_out     = cand_sum[15:0];
         res_in.slot_out     = 3'(free_idx);
      end
      // mask reflects the table after the command
      for (int i = 0; i < MW; i++) begin
         res_in.ready_mask[i] = (status_in[i] == SL_PIXELS);
      end
   end

   always_comb begin
      pcount_in = csr_we ? csr_wdata : pcount_ff;
      k_in      = k_ff;
      if (ctrl.capture) begin
         k_in = '0;
      end else if (ctrl.cand_next) begin
         k_in = k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= '0;
         focus_ff  <= '0;
         k_ff      <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            status_ff[i] <= SL_FREE;
         end
      end else begin
         pcount_ff <= pcount_in;
         focus_ff  <= focus_in;
         k_ff      <= k_in;
         status_ff <= status_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         req_ff <= req_data;
      end
      if (ctrl.exec || ctrl.claim_done) begin
         res_ff <= res_in;
      end
      if (page_we) begin
         page_ff[free_idx] <= cand_sum[15:0];
      end
      if (size_we) begin
         width_ff[sel_idx]  <= req_ff.width;
         height_ff[sel_idx] <= req_ff.height;
      end
   end

   assign rsp_data = res_ff;

endmodule

`default_nettype wire

FILE: rtl/window_prefetch_slot_manager_unit.sv
// ----------------------------------------------------------------------------
// window_prefetch_slot_manager_unit: page window slot manager, top level
// Caches pages around a focus page in a small slot table.
// ----------------------------------------------------------------------------
// One request beat in, one response beat out, one command at a time. Focus,
// load done, sweep, upload done and lookup each pass through accept, execute
// across all slot lanes at once, and present. A claim follows its execute
// state with a walk over its candidate pages, one per cycle through the shared
// compare lanes: focus, focus+1..focus+AHEAD, focus-1..focus-BEHIND, stopping
// at the first page that is in range and not already held, and then presents
// its response. rsp_valid is high while the response is presented and holds
// until rsp_ready. A new request is taken only after the response beat has
// been taken. The page count register must be written through csr_we/csr_wdata
// only while the block is idle; the block itself does not enforce this.
// ready_mask in each response shows the pixels slots after that command;
// lookup/claim fields are zero where not used.
// Slot page and size entries have no reset and are only read after written.
// ----------------------------------------------------------------------------
`default_nettype none

module window_prefetch_slot_manager_unit import wpsm_pkg::*; #(
   parameter int SLOTS  = DEF_SLOTS,
   parameter int AHEAD  = DEF_AHEAD,
   parameter int BEHIND = DEF_BEHIND
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   // page count register
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   ctrl_cmd_type  ctrl;
   dp_status_type status;

   // sequencer: one-hot FSM
   wpsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   // slot table and result register
   wpsm_datapath #(
      .SLOTS  (SLOTS),
      .AHEAD  (AHEAD),
      .BEHIND (BEHIND)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

   // one command in flight: never ready for a request while a response waits
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while response pending");

   // a response handshake returns the block to idle
   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready)
      else $error("not idle after response beat");

   // at most one datapath command per cycle
   a_ctrl_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.capture, ctrl.exec, ctrl.cand_next, ctrl.claim_done}))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

FILE: test/tb_window_prefetch_slot_manager_unit.sv
// ----------------------------------------------------------------------------
// tb_window_prefetch_slot_manager_unit: self-checking bench for the slot manager
// A directed opener, then random command streams over several page counts,
// each response beat checked field by field against an in-bench slot table.
// ----------------------------------------------------------------------------

module tb_window_prefetch_slot_manager_unit;
   import wpsm_pkg::*;

   localparam int SLOTS  = DEF_SLOTS;
   localparam int AHEAD  = DEF_AHEAD;
   localparam int BEHIND = DEF_BEHIND;

   // codes outside the command set; the block must treat them as no-ops
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam int PHASES      = 8;
   localparam int PHASE_BEATS = 130;
   localparam int CALM_PHASE  = 5;
   localparam int CYCLE_LIMIT = 300000;

   // slot table as the bench sees it
   typedef struct packed {
      logic [15:0]           count;
      logic [15:0]           focus;
      logic [SLOTS-1:0][2:0]  state;
      logic [SLOTS-1:0][15:0] page;
      logic [SLOTS-1:0][15:0] wid;
      logic [SLOTS-1:0][15:0] hgt;
   } slot_table_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   // page count settings for the random phases, extremes included
   logic [15:0] count_steps [PHASES] = '{16'd7, 16'd65535, 16'd0, 16'd1,
                                          16'd3, 16'd40, 16'd65535, 16'd12};

   req_type        cmd_q [$];      // commands waiting for the driver
   rsp_type        rsp_due_q [$];  // responses owed by the block, oldest first
   slot_table_type live_table;     // advanced at each accepted request beat
   slot_table_type plan_table;     // advanced as commands are queued
   rsp_type        seen_due;
   bit             calm = 1'b0;
   int             errors = 0;
   int             cycle_cnt = 0;
   int             beats_checked = 0;
   int             grants = 0;
   int             tex_hits = 0;
   int             frees = 0;
   int             settings = 0;

   window_prefetch_slot_manager_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Apply one command to a slot table and return the response beat it owes.
   function automatic rsp_type table_step(inout slot_table_type t, input req_type r);
      rsp_type o;
      int      cand;
      int      p;
      int      free_slot;
      int      s;
      int      f;
      int      q;
      bit      held;
      o = '0;
      f = int'(t.focus);
      case (r.cmd)
         OP_FOCUS: t.focus = r.page;
         OP_CLAIM: begin
            // focus, then ahead, then behind; first page in range and not held
            cand = -1;
            for (int k = 0; k <= AHEAD + BEHIND; k++) begin
               p = (k <= AHEAD) ? f + k : f - (k - AHEAD);
               held = 1'b0;
               for (int i = 0; i < SLOTS; i++)
                  if (t.state[i] != SL_FREE && int'(t.page[i]) == p) held = 1'b1;
               if (cand < 0 && p >= 0 && p < int'(t.count) && !held) cand = p;
            end
            free_slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (t.state[i] == SL_FREE) free_slot = i;
            // a candidate with no free slot grants nothing
            if (cand >= 0 && free_slot >= 0) begin
               t.page[free_slot]  = 16'(cand);
               t.state[free_slot] = SL_LOADING;
               o.valid_res = 1'b1;
               o.page_out  = 16'(cand);
               o.slot_out  = 3'(free_slot);
            end
         end
         OP_LOAD_DONE: begin
            s = int'(r.slot);
            if (s < SLOTS) begin
               if (t.state[s] == SL_LOADING) begin
                  if (r.ok) begin
                     t.wid[s]   = r.width;
                     t.hgt[s]   = r.height;
                     t.state[s] = SL_PIXELS;
                  end else begin
                     t.state[s] = SL_FAILED;
                  end
               end
            end
         end
         OP_SWEEP: begin
            for (int i = 0; i < SLOTS; i++) begin
               q = int'(t.page[i]);
               if ((t.state[i] == SL_PIXELS || t.state[i] == SL_TEXTURE ||
                    t.state[i] == SL_FAILED) &&
                   !(q >= f - BEHIND && q <= f + AHEAD && q < int'(t.count))) begin
                  t.state[i] = SL_FREE;
                  o.freed    = 1'b1;
               end
            end
         end
         OP_UPLOAD: begin
            s = int'(r.slot);
            if (s < SLOTS) begin
               if (t.state[s] == SL_PIXELS)
                  t.state[s] = r.ok ? SL_TEXTURE : SL_FAILED;
            end
         end
         OP_LOOKUP: begin
            // lowest slot holding the page wins
            s = -1;
            for (int i = SLOTS - 1; i >= 0; i--)
               if (t.state[i] != SL_FREE && t.page[i] == r.page) s = i;
            if (s >= 0) begin
               o.slot_out = 3'(s);
               if (t.state[s] == SL_TEXTURE) begin
                  o.valid_res  = 1'b1;
                  o.width_out  = t.wid[s];
                  o.height_out = t.hgt[s];
               end else if (t.state[s] == SL_FAILED) begin
                  o.failed = 1'b1;
               end
            end
         end
         default: ;
      endcase
      for (int i = 0; i < SLOTS && i < MASK_W; i++)
         o.ready_mask[i] = (t.state[i] == SL_PIXELS);
      return o;
   endfunction

   function automatic req_type make_cmd(input logic [2:0] op, input logic [15:0] page,
                                        input logic [2:0] slot, input logic ok,
                                        input logic [15:0] w, input logic [15:0] h);
      req_type r;
      r.cmd    = op;
      r.page   = page;
      r.slot   = slot;
      r.ok     = ok;
      r.width  = w;
      r.height = h;
      return r;
   endfunction

   // Mostly well-formed: completions aim at slots in the right state and
   // lookups at held pages. A few beats go to wrong or out-of-range slots.
   function automatic req_type random_cmd(input slot_table_type t);
      req_type    r;
      int         pick;
      int         sel;
      int         n;
      int         pool [SLOTS];
      logic [2:0] want;
      r.cmd    = OP_FOCUS;
      r.page   = 16'($urandom);
      r.slot   = 3'($urandom_range(0, SLOTS - 1));
      r.ok     = 1'($urandom);
      r.width  = 16'($urandom);
      r.height = 16'($urandom);
      want     = SL_FREE;
      n        = 0;
      pick     = $urandom_range(0, 99);
      if (pick < 12) begin
         r.cmd = OP_FOCUS;
         sel = $urandom_range(0, 19);
         if (sel == 0) r.page = 16'd0;
         else if (sel == 1) r.page = 16'hFFFF;
         else if (sel == 2) r.page = t.count - 16'd1;
         else if (sel < 5) r.page = 16'($urandom);
         else if (sel < 12 || t.count == 16'd0)
            r.page = 16'(int'(t.focus) + $urandom_range(0, 7) - 3);
         else r.page = 16'($urandom_range(0, int'(t.count)));
      end else if (pick < 37) begin
         r.cmd = OP_CLAIM;
      end else if (pick < 57) begin
         r.cmd = OP_LOAD_DONE;
         want  = SL_LOADING;
         r.ok  = ($urandom_range(0, 9) != 0);
      end else if (pick < 67) begin
         r.cmd = OP_SWEEP;
      end else if (pick < 80) begin
         r.cmd = OP_UPLOAD;
         want  = SL_PIXELS;
         r.ok  = ($urandom_range(0, 19) > 2);
      end else if (pick < 95) begin
         r.cmd = OP_LOOKUP;
         for (int i = 0; i < SLOTS; i++)
            if (t.state[i] != SL_FREE) begin
               pool[n] = i;
               n++;
            end
         sel = $urandom_range(0, 9);
         if (n > 0 && sel < 7) r.page = t.page[pool[$urandom_range(0, n - 1)]];
         else if (sel < 9) r.page = 16'(int'(t.focus) + $urandom_range(0, 5) - 2);
      end else begin
         // stray completion, possibly past the last slot
         r.cmd  = ($urandom_range(0, 1) != 0) ? OP_LOAD_DONE : OP_UPLOAD;
         r.slot = 3'($urandom_range(0, 7));
      end
      if (want != SL_FREE) begin
         for (int i = 0; i < SLOTS; i++)
            if (t.state[i] == want) begin
               pool[n] = i;
               n++;
            end
         if (n > 0 && $urandom_range(0, 9) != 0) r.slot = 3'(pool[$urandom_range(0, n - 1)]);
      end
      return r;
   endfunction

   task automatic queue_cmd(input req_type r);
      void'(table_step(plan_table, r));
      cmd_q.push_back(r);
   endtask

   // hold off until every queued command is out and every response is in
   task automatic drain();
      while (cmd_q.size() != 0 || req_valid || rsp_due_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_page_count(input logic [15:0] value);
      drain();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      live_table.count = value;
      plan_table.count = value;
      settings++;
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // Driver: model advances on the accepting edge; payload holds while waiting.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && req_ready) rsp_due_q.push_back(table_step(live_table, req_data));
         if (!req_valid || req_ready) begin
            if (cmd_q.size() != 0 && (calm || $urandom_range(0, 99) >= 26)) begin
               req_valid <= 1'b1;
               req_data  <= cmd_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: each response beat against the oldest owed response.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_due_q.size() == 0) begin
               $display("%0t: response beat with none owed, actual %h", $time, rsp_data);
               errors++;
            end else begin
               seen_due = rsp_due_q.pop_front();
               check_field("valid_res", 16'(seen_due.valid_res), 16'(rsp_data.valid_res));
               check_field("page_out", seen_due.page_out, rsp_data.page_out);
               check_field("slot_out", 16'(seen_due.slot_out), 16'(rsp_data.slot_out));
               check_field("width_out", seen_due.width_out, rsp_data.width_out);
               check_field("height_out", seen_due.height_out, rsp_data.height_out);
               check_field("failed", 16'(seen_due.failed), 16'(rsp_data.failed));
               check_field("freed", 16'(seen_due.freed), 16'(rsp_data.freed));
               check_field("ready_mask", 16'(seen_due.ready_mask), 16'(rsp_data.ready_mask));
               beats_checked++;
               if (seen_due.valid_res && seen_due.page_out == 16'd0 &&
                   seen_due.width_out != 16'd0) tex_hits++;
               if (seen_due.freed) frees++;
            end
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 26);
      end
   end

   // count claim beats as they are accepted
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready && req_data.cmd == OP_CLAIM) grants++;
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("window_prefetch_slot_manager_unit verification failed");
         $finish;
      end
   end

   initial begin
      live_table = '0;
      plan_table = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed opener at a page count of 100, focus at 0 after reset.
      set_page_count(16'd100);
      queue_cmd(make_cmd(OP_LOOKUP, 16'd0, 3'd0, 1'b0, 16'd0, 16'd0));   // empty table
      queue_cmd(make_cmd(OP_CLAIM, 16'd0, 3'd0, 1'b0, 16'd0, 16'd0));    // page 0
      queue_cmd(make_cmd(OP_CLAIM, 16'd0, 3'd0, 1'b0, 16'd0, 16'd0));    // page 1
      queue_cmd(make_cmd(OP_CLAIM, 16'd0, 3'd0, 1'b0, 16'd0, 16'd0));    // page 2
      queue_cmd(make_cmd(OP_CLAIM, 16'd0, 3'd0, 1'b0, 16'd0, 16'd0));    // behind is -1
      queue_cmd(make_cmd(OP_LOAD_DONE, 16'd0, 3'd0, 1'b1, 16'hFFFF, 16'h0000));
      queue_cmd(make_cmd(OP_LOAD_DONE, 16'd0, 3'd1, 1'b0, 16'h1234, 16'h5678));
      queue_cmd(make_cmd(OP_LOAD_DONE, 16'd0, 3'd7, 1'b1, 16'h0001, 16'h0001));
      queue_cmd(make_cmd(OP_UPLOAD, 16'd0, 3'd0, 1'b1, 16'd0, 16'd0));
      queue_cmd(make_cmd(OP_UPLOAD, 16'd0, 3'd2, 1'b1, 16'd0, 16'd0));   // still loading
      queue_cmd(make_cmd(OP_LOOKUP, 16'd0, 3'd0, 1'b0, 16'd0, 16'd0));   // texture
      queue_cmd(make_cmd(OP_LOOKUP, 16'd1, 3'd0, 1'b0, 16'd0, 16'd0));   // failed
      queue_cmd(make_cmd(OP_LOAD_DONE, 16'd0, 3'd2, 1'b1, 16'h0000, 16'hFFFF));
      queue_cmd(make_cmd(OP_UPLOAD, 16'd0, 3'd2, 1'b0, 16'd0, 16'd0));   // size kept
      queue_cmd(make_cmd(OP_SPARE_6, 16'hFFFF, 3'd5, 1'b1, 16'hFFFF, 16'hFFFF));
      queue_cmd(make_cmd(OP_SPARE_7, 16'hA5A5, 3'd2, 1'b1, 16'h5A5A, 16'hA5A5));
      queue_cmd(make_cmd(OP_FOCUS, 16'hFFFF, 3'd0, 1'b0, 16'd0, 16'd0));
      queue_cmd(make_cmd(OP_CLAIM, 16'd0, 3'd0, 1'b0, 16'd0, 16'd0));    // all out of range
      queue_cmd(make_cmd(OP_SWEEP, 16'd0, 3'd0, 1'b0, 16'd0, 16'd0));
      queue_cmd(make_cmd(OP_FOCUS, 16'd50, 3'd0, 1'b0, 16'd0, 16'd0));
      repeat (4) queue_cmd(make_cmd(OP_CLAIM, 16'd0, 3'd0, 1'b0, 16'd0, 16'd0));
      queue_cmd(make_cmd(OP_FOCUS, 16'd60, 3'd0, 1'b0, 16'd0, 16'd0));
      repeat (2) queue_cmd(make_cmd(OP_CLAIM, 16'd0, 3'd0, 1'b0, 16'd0, 16'd0));
      queue_cmd(make_cmd(OP_CLAIM, 16'd0, 3'd0, 1'b0, 16'd0, 16'd0));    // table full

      // Random phases; each boundary drains the block before the write.
      for (int ph = 0; ph < PHASES; ph++) begin
         set_page_count(count_steps[ph]);
         calm = (ph == CALM_PHASE);
         for (int n = 0; n < PHASE_BEATS; n++) queue_cmd(random_cmd(plan_table));
      end
      drain();

      $display("checked %0d response beats over %0d page count settings", beats_checked,
               settings);
      $display("claims sent %0d, texture lookups %0d, sweeps that freed slots %0d",
               grants, tex_hits, frees);
      if (errors == 0) begin
         $display("window_prefetch_slot_manager_unit verification clean");
      end else begin
         $display("window_prefetch_slot_manager_unit verification failed");
      end
      $finish;
   end

endmodule
